[sv/lpht_pkg.sv]
package lpht_pkg;
  localparam int SLOTS = 1024;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int KEY_BITS = 64;
  localparam int VALUE_BITS = 64;
  localparam int COUNT_BITS = SLOT_BITS + 1;
  localparam int LOAD_DIVISOR = 3;
  // Smallest entry count at which count + count / LOAD_DIVISOR reaches SLOTS.
  localparam int LOAD_LIMIT = (LOAD_DIVISOR * SLOTS + LOAD_DIVISOR) / (LOAD_DIVISOR + 1);

  localparam logic [2:0] ST_GET_HIT = 3'd0;
  localparam logic [2:0] ST_GET_MISS = 3'd1;
  localparam logic [2:0] ST_SET_INSERTED = 3'd2;
  localparam logic [2:0] ST_SET_REPLACED = 3'd3;
  localparam logic [2:0] ST_SET_FULL = 3'd4;

  typedef struct packed {
    logic mode;
    logic [63:0] key;
    logic [63:0] key_hash;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [63:0] read_value;
    logic slot_valid;
    logic [9:0] slot;
  } out_item_t;

  typedef struct packed {
    logic mode;
    logic [KEY_BITS-1:0] key;
    logic [63:0] key_hash;
    logic [VALUE_BITS-1:0] value;
  } req_t;
endpackage

[sv/linear_probe_hash_table_unit.sv]
// Each accepted beat passes S_READ and S_CHECK once per probed slot (one read each), then S_DONE.
// The back handles one item at a time and takes no new beat until it is back in S_IDLE.
// A two-entry queue lets the front accept beats while the back is probing.
// Reset (synchronous, active low) clears the entry count and both queues; a pass over all
// 1024 slots then clears occupancy before the first beat is taken from the queue.
module linear_probe_hash_table_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  lpht_pkg::in_item_t in_data,
  output logic out_empty,
  input  logic out_pop,
  output lpht_pkg::out_item_t out_data
);
  logic req_valid, req_take;
  lpht_pkg::req_t req_data;

  lpht_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .req_valid, .req_take, .req_data
  );

  lpht_back u_back (
    .clk, .rst_n, .req_valid, .req_take, .req_data,
    .out_empty, .out_pop, .out_data
  );
endmodule

[sv/lpht_front.sv]
module lpht_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  lpht_pkg::in_item_t in_data,
  output logic req_valid,
  input  logic req_take,
  output lpht_pkg::req_t req_data
);
  lpht_pkg::req_t q_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  lpht_pkg::req_t r;
  logic push_ok, pop_ok;

  assign in_full = cnt_r == 2'd2;
  assign push_ok = in_push && !in_full;
  assign pop_ok = req_take && req_valid;
  assign req_valid = cnt_r != 2'd0;
  assign req_data = q_r[rp_r];

  always_comb begin
    r.mode = in_data.mode;
    r.key = in_data.key[lpht_pkg::KEY_BITS-1:0];
    r.key_hash = in_data.key_hash;
    r.value = in_data.value[lpht_pkg::VALUE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= r;
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push_ok) wp_r <= !wp_r;
      if (pop_ok) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end
endmodule

[sv/lpht_back.sv]
module lpht_back (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  output logic req_take,
  input  lpht_pkg::req_t req_data,
  output logic out_empty,
  input  logic out_pop,
  output lpht_pkg::out_item_t out_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam int SB = lpht_pkg::SLOT_BITS;
  localparam int CB = lpht_pkg::COUNT_BITS;

  logic [lpht_pkg::KEY_BITS-1:0] key_mem [lpht_pkg::SLOTS];
  logic [63:0] hash_mem [lpht_pkg::SLOTS];
  logic [lpht_pkg::VALUE_BITS-1:0] val_mem [lpht_pkg::SLOTS];
  logic occ_mem [lpht_pkg::SLOTS];

  logic [2:0] state_r, state_nxt;
  lpht_pkg::req_t cur_r;
  logic [SB-1:0] pos_r;
  logic [SB-1:0] clr_r;
  logic [SB:0] n_r;
  logic [CB-1:0] count_r;
  logic at_limit_r;
  logic [lpht_pkg::KEY_BITS-1:0] rk_r;
  logic [63:0] rh_r;
  logic [lpht_pkg::VALUE_BITS-1:0] rv_r;
  logic ro_r;
  lpht_pkg::out_item_t fin_r;
  lpht_pkg::out_item_t res_r;
  logic full_r;
  logic match, stop, wr_en, load_out;

  assign req_take = state_r == S_IDLE && req_valid;
  assign out_empty = !full_r;
  assign out_data = res_r;
  assign match = ro_r && rh_r == cur_r.key_hash && rk_r == cur_r.key;
  assign stop = !ro_r || match;
  assign wr_en = state_r == S_CHECK && stop && cur_r.mode && (ro_r || !at_limit_r);
  assign load_out = state_r == S_DONE && (!full_r || out_pop);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == SB'(lpht_pkg::SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (req_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_CHECK;
      S_CHECK: if (stop || n_r == (SB+1)'(lpht_pkg::SLOTS - 1)) state_nxt = S_DONE;
               else state_nxt = S_READ;
      S_DONE: if (!full_r || out_pop) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rk_r <= key_mem[pos_r];
      rh_r <= hash_mem[pos_r];
      rv_r <= val_mem[pos_r];
      ro_r <= occ_mem[pos_r];
    end
    if (state_r == S_CLEAR) occ_mem[clr_r] <= 1'b0;
    else if (wr_en && !ro_r) occ_mem[pos_r] <= 1'b1;
    if (wr_en) begin
      val_mem[pos_r] <= cur_r.value;
      if (!ro_r) begin
        key_mem[pos_r] <= cur_r.key;
        hash_mem[pos_r] <= cur_r.key_hash;
      end
    end
    if (req_take) begin
      cur_r <= req_data;
      pos_r <= req_data.key_hash[SB-1:0];
      at_limit_r <= count_r >= CB'(lpht_pkg::LOAD_LIMIT);
    end
    if (state_r == S_CHECK && !stop) pos_r <= pos_r + 1'b1;
    if (state_r == S_CHECK && (stop || n_r == (SB+1)'(lpht_pkg::SLOTS - 1))) begin
      fin_r.slot_valid <= stop;
      fin_r.slot <= stop ? 10'(pos_r) : '0;
      fin_r.read_value <= (!cur_r.mode && match) ? 64'(rv_r) : '0;
      if (!cur_r.mode) fin_r.status <= match ? lpht_pkg::ST_GET_HIT : lpht_pkg::ST_GET_MISS;
      else if (match) fin_r.status <= lpht_pkg::ST_SET_REPLACED;
      else if (stop && !at_limit_r) fin_r.status <= lpht_pkg::ST_SET_INSERTED;
      else fin_r.status <= lpht_pkg::ST_SET_FULL;
    end
    if (load_out) res_r <= fin_r;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      count_r <= '0;
      full_r <= 1'b0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (req_take) n_r <= '0;
      else if (state_r == S_CHECK) n_r <= n_r + 1'b1;
      if (wr_en && !ro_r) count_r <= count_r + 1'b1;
      if (load_out) full_r <= 1'b1;
      else if (out_pop && full_r) full_r <= 1'b0;
    end
  end
endmodule
